FILE: src/smrm_pkg.sv
// Shared widths, register indexes and control/status types for the seam-to-mask run unit.
package smrm_pkg;

	localparam int IDX_W      = 8;
	localparam int LEN_W      = 24;
	localparam int LEFT_W     = 25;
	localparam int IMG_CNT_W  = 7;
	localparam int TGT_W      = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam int TDATA_W    = 32;

	localparam int MAX_IMAGES_DEF = 64;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'b1;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;  // take the input transaction, latch item, advance row state
		logic emit;    // load the next result into the output register
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic has_results; // clamped image count is nonzero
		logic out_free;    // output register empty or being drained this cycle
		logic at_last;     // current image is the final one of this item
	} dp_status_t;

endpackage

FILE: src/smrm_ctrl.sv
// Controller state machine: sequences accept and per-image result emission.
module smrm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  smrm_pkg::dp_status_t  status,
	output smrm_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q;
	state_t state_next;

	// Accept only between items
	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.accept = s_tvalid && s_tready;
	assign cmd.emit   = (state_q == ST_EMIT) && status.out_free;

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && status.has_results) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.emit && status.at_last) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Emission never overlaps acceptance
	assert property (@(posedge clk) disable iff (!arst_n) !(cmd.accept && cmd.emit))
		else $error("accept and emit in the same cycle");

	// Last emission returns the controller to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && status.at_last) |=> s_tready)
		else $error("controller did not return to idle after last result");

endmodule

FILE: src/smrm_dpath.sv
// Datapath: configuration, row tracking, item latch, image counter and output register.
module smrm_dpath #(
	parameter int MaxImages = smrm_pkg::MAX_IMAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [smrm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smrm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [smrm_pkg::TDATA_W-1:0]         s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [smrm_pkg::TDATA_W-1:0]         m_tdata,
	output logic                                 m_tlast,
	input  smrm_pkg::ctrl_cmd_t                  cmd,
	output smrm_pkg::dp_status_t                 status
);

	localparam logic [smrm_pkg::IMG_CNT_W-1:0] MAX_N = smrm_pkg::IMG_CNT_W'(MaxImages);

	logic [smrm_pkg::IMG_CNT_W-1:0] image_count_q;
	logic [smrm_pkg::LEN_W-1:0]     row_width_q;
	logic [smrm_pkg::LEFT_W-1:0]    pixels_left_q;
	logic [smrm_pkg::IDX_W-1:0]     prev_image_q;
	logic                           row_started_q;

	logic [smrm_pkg::IDX_W-1:0]     item_idx_q;
	logic [smrm_pkg::IDX_W-1:0]     item_prev_q;
	logic [smrm_pkg::LEN_W-1:0]     item_len_q;
	logic                           item_start_q;
	logic [smrm_pkg::IMG_CNT_W-1:0] n_q;
	logic [smrm_pkg::TGT_W-1:0]     cnt_q;

	logic                           out_valid_q;
	logic [smrm_pkg::TDATA_W-1:0]   out_data_q;
	logic                           out_last_q;

	logic [smrm_pkg::IDX_W-1:0]     in_idx;
	logic [smrm_pkg::LEN_W-1:0]     in_len;
	logic [smrm_pkg::IMG_CNT_W-1:0] n_eff;
	logic [smrm_pkg::LEFT_W-1:0]    left;
	logic [smrm_pkg::LEFT_W-1:0]    len_ext;
	logic [smrm_pkg::LEFT_W-1:0]    left_next;
	logic [smrm_pkg::IDX_W-1:0]     cur_img;
	logic                           is_prev;
	logic                           is_idx;
	logic                           res_extend;
	logic                           res_value;

	assign in_idx = s_tdata[smrm_pkg::IDX_W-1:0];
	assign in_len = s_tdata[smrm_pkg::IDX_W +: smrm_pkg::LEN_W];

	// Clamp the image count to the supported maximum
	assign n_eff = (image_count_q > MAX_N) ? MAX_N : image_count_q;

	// Pixels left after this run, saturating at zero
	assign left      = row_started_q ? pixels_left_q : {1'b0, row_width_q};
	assign len_ext   = {1'b0, in_len};
	assign left_next = (len_ext >= left) ? '0 : (left - len_ext);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_count_q <= smrm_pkg::IMG_CNT_W'(1);
			row_width_q   <= smrm_pkg::LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				smrm_pkg::REG_IMAGE_COUNT: image_count_q <= cfg_data[smrm_pkg::IMG_CNT_W-1:0];
				smrm_pkg::REG_ROW_WIDTH:   row_width_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance row state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_left_q <= '0;
			prev_image_q  <= '0;
			row_started_q <= 1'b0;
		end else if (cmd.accept) begin
			pixels_left_q <= left_next;
			prev_image_q  <= in_idx;
			row_started_q <= (left_next != '0);
		end
	end

	// Latch the item for emission
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_idx_q   <= in_idx;
			item_prev_q  <= prev_image_q;
			item_len_q   <= in_len;
			item_start_q <= !row_started_q;
			n_q          <= n_eff;
		end
	end

	// Image counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.accept) begin
			cnt_q <= '0;
		end else if (cmd.emit) begin
			cnt_q <= cnt_q + smrm_pkg::TGT_W'(1);
		end
	end

	// Result for the current image
	assign cur_img    = {{(smrm_pkg::IDX_W-smrm_pkg::TGT_W){1'b0}}, cnt_q};
	assign is_prev    = (cur_img == item_prev_q);
	assign is_idx     = (cur_img == item_idx_q);
	assign res_extend = !item_start_q && !is_prev && !is_idx;
	assign res_value  = item_start_q ? is_idx : (!is_prev && is_idx);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {res_value, item_len_q, res_extend, cnt_q};
			out_last_q <= status.at_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// Status to the controller
	assign status.has_results = (n_eff != '0);
	assign status.out_free    = !out_valid_q || m_tready;
	assign status.at_last     = ({1'b0, cnt_q} == (n_q - smrm_pkg::IMG_CNT_W'(1)));

	// Counter stays inside the item's image range while emitting
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> ({1'b0, cnt_q} < n_q))
		else $error("image counter past image count");

	// Row in progress always has pixels left
	assert property (@(posedge clk) disable iff (!arst_n) row_started_q |-> (pixels_left_q != '0))
		else $error("row marked started with no pixels left");

endmodule

FILE: src/seam_runs_to_mask_runs_unit.sv
// Top level: seam runs in, per-image mask run updates out.
//
//   channel | dir | handshake            | payload (low bit first)
//   s_*     | in  | s_tvalid / s_tready  | tdata: image_index[7:0], run_length[31:8]
//   m_*     | out | m_tvalid / m_tready  | tdata: target_image, extend_previous,
//           |     |                      |        run_count, mask_value; tlast: last_result
//   cfg_*   | in  | cfg_we               | cfg_index (0 image_count, 1 row_width), cfg_data
//
// An item yields N = min(image_count, MaxImages) results: it is accepted first, then
// one result per cycle enters the output register while the output is not stalled,
// paced by the image counter. With N = 0 the item is accepted and produces no transaction.
// Reset (arst_n low) sets image_count and row_width to 1 and starts a fresh row.
// A stalled output holds the current result and pauses the image counter; the next
// item is accepted while the final result of the previous one still waits.
module seam_runs_to_mask_runs_unit #(
	parameter int MaxImages = smrm_pkg::MAX_IMAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [smrm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [smrm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [smrm_pkg::TDATA_W-1:0]        s_tdata,  // image_index[7:0], run_length[31:8]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [smrm_pkg::TDATA_W-1:0]        m_tdata,  // target_image[5:0], extend_previous[6],
	                                                      // run_count[30:7], mask_value[31]
	output logic                                m_tlast
);

	smrm_pkg::ctrl_cmd_t  cmd;
	smrm_pkg::dp_status_t status;

	smrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	smrm_dpath #(
		.MaxImages (MaxImages)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
